/* sv/derq_pkg.sv */
// ----------------------------------------------------------------------------
// derq_pkg
// Shared types and codes for the double-ended ring queue unit.
// ----------------------------------------------------------------------------
package derq_pkg;

   // operation codes carried by a request
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_REAR   = 3'd3;
   localparam logic [2:0] OP_NONE       = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   // configuration register file
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam logic        CSR_IDX_CAPACITY = 1'b0;
   localparam int unsigned CAPACITY_W   = 5;
   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_LOAD = 3'b100
   } derq_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic exec;
      logic load;
   } derq_cmd_type;

endpackage

/* sv/double_ended_ring_queue_unit.sv */
// ----------------------------------------------------------------------------
// double_ended_ring_queue_unit
// Double-ended queue in a ring store with push and pop at both ends.
// ----------------------------------------------------------------------------
// Each request goes through acceptance, a store read and a result load: the
// operation updates the pointers and writes the ring store in the accept
// cycle, the store is read through its registered read ports in the next,
// and the result register is loaded in the load state when the output is
// free. A new request is taken as soon as the result is loaded, even while
// that result still waits for rsp_ready. The capacity register may be
// written only while the queue is empty; writes at other times are dropped.
module double_ended_ring_queue_unit import derq_pkg::*; #(
   parameter int unsigned DEPTH       = 16,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_operation,
   input  logic signed [31:0]    req_push_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic signed [31:0]    rsp_front_value,
   output logic signed [31:0]    rsp_rear_value,
   output logic                  rsp_values_valid,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   derq_cmd_type          cmd;
   logic                  cap_we;
   logic [CAPACITY_W-1:0] cap_value;
   logic                  csr_hit;

   // register decode
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_CAPACITY);
   assign cap_we     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(cap_value) : '0;

   derq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   derq_dpath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_operation    (req_operation),
      .req_push_value   (req_push_value),
      .cap_we           (cap_we),
      .cap_wdata        (csr_pwdata[CAPACITY_W-1:0]),
      .cap_value        (cap_value),
      .rsp_status       (rsp_status),
      .rsp_front_value  (rsp_front_value),
      .rsp_rear_value   (rsp_rear_value),
      .rsp_values_valid (rsp_values_valid),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full)
   );

endmodule

/* sv/derq_ctrl.sv */
// ----------------------------------------------------------------------------
// derq_ctrl
// Sequencer: accepts a request, waits for the store read, then loads the
// result register and manages the response valid.
// ----------------------------------------------------------------------------
module derq_ctrl import derq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output derq_cmd_type cmd
);

   derq_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // handshake decode
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd.exec  = req_valid && req_ready;
   assign cmd.load  = (state_ff == S_LOAD) && out_free;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.exec) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      priority if (cmd.load) rsp_valid_in = 1'b1;
      else if (rsp_ready)    rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   // a request is only taken when no earlier one is still in flight
   a_exec_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> state_ff == S_IDLE)
      else $error("request taken outside idle");

   // an accepted request always reaches the read state next
   a_exec_read: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> state_ff == S_READ)
      else $error("read state skipped");

   // loading the result never drops a pending response
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");
`endif

endmodule

/* sv/derq_dpath.sv */
// ----------------------------------------------------------------------------
// derq_dpath
// Ring store, head and tail pointers, capacity register and result
// registers of the double-ended queue.
// ----------------------------------------------------------------------------
module derq_dpath import derq_pkg::*; #(
   parameter int unsigned DEPTH       = 16,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  derq_cmd_type          cmd,
   input  logic [2:0]            req_operation,
   input  logic signed [31:0]    req_push_value,
   input  logic                  cap_we,
   input  logic [CAPACITY_W-1:0] cap_wdata,
   output logic [CAPACITY_W-1:0] cap_value,
   output logic [1:0]            rsp_status,
   output logic signed [31:0]    rsp_front_value,
   output logic signed [31:0]    rsp_rear_value,
   output logic                  rsp_values_valid,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CAP_W = PTR_W + 1;
   localparam int unsigned CMP_W = (CAP_W > CAPACITY_W) ? CAP_W : CAPACITY_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic                   empty_ff, empty_in;
   logic [CAPACITY_W-1:0]  capacity_ff;
   logic [1:0]             status_ff, status_in;

   logic [VALUE_WIDTH-1:0] store_mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_front_ff, rd_rear_ff;
   logic                   store_we;
   logic [PTR_W-1:0]       store_waddr;
   logic [VALUE_WIDTH-1:0] store_wdata;

   logic [CMP_W-1:0]       cap_ext;
   logic [CAP_W-1:0]       cap_eff;
   logic                   is_push, is_pop, full_now;
   logic [PTR_W-1:0]       head_prev, head_next, tail_prev, tail_next;
   logic [31:0]            front_ext, rear_ext;

   logic [1:0]             rsp_status_ff;
   logic signed [31:0]     rsp_front_ff, rsp_rear_ff;
   logic                   rsp_valid_flag_ff, rsp_empty_ff, rsp_full_ff;

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] c);
      logic [CAP_W-1:0] p1;
      p1 = CAP_W'(p) + CAP_W'(1);
      return (p1 >= c) ? '0 : p1[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] prev_pos(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] c);
      logic [CAP_W-1:0] cm1;
      cm1 = c - CAP_W'(1);
      return (p == '0 || CAP_W'(p) >= c) ? cm1[PTR_W-1:0] : p - PTR_W'(1);
   endfunction

   // effective capacity: zero acts as one, clamp at the ring depth
   assign cap_ext = CMP_W'(capacity_ff);
   always_comb begin
      priority if (cap_ext == '0)    cap_eff = CAP_W'(1);
      else if (cap_ext > DEPTH_C)    cap_eff = CAP_W'(DEPTH);
      else                           cap_eff = cap_ext[CAP_W-1:0];
   end

   // pointer neighbors and full detect
   assign head_prev = prev_pos(head_ff, cap_eff);
   assign head_next = next_pos(head_ff, cap_eff);
   assign tail_prev = prev_pos(tail_ff, cap_eff);
   assign tail_next = next_pos(tail_ff, cap_eff);
   assign full_now  = !empty_ff && (head_ff == tail_next);

   assign is_push = (req_operation == OP_PUSH_FRONT) || (req_operation == OP_PUSH_REAR);
   assign is_pop  = (req_operation == OP_POP_FRONT) || (req_operation == OP_POP_REAR);

   // store write data, cut or padded to the entry width
   generate
      if (VALUE_WIDTH <= 32) begin : g_wr_narrow
         assign store_wdata = req_push_value[VALUE_WIDTH-1:0];
      end else begin : g_wr_wide
         assign store_wdata = {{(VALUE_WIDTH-32){1'b0}}, req_push_value};
      end
   endgenerate

   // operation execute: pointer update and store write
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      empty_in    = empty_ff;
      status_in   = status_ff;
      store_we    = 1'b0;
      store_waddr = head_ff;
      if (cmd.exec) begin
         priority if (is_push && full_now) begin
            status_in = ST_OVERFLOW;
         end else if (is_push && empty_ff) begin
            status_in   = ST_OK;
            head_in     = '0;
            tail_in     = '0;
            empty_in    = 1'b0;
            store_we    = 1'b1;
            store_waddr = '0;
         end else if (req_operation == OP_PUSH_FRONT) begin
            status_in   = ST_OK;
            head_in     = head_prev;
            store_we    = 1'b1;
            store_waddr = head_prev;
         end else if (req_operation == OP_PUSH_REAR) begin
            status_in   = ST_OK;
            tail_in     = tail_next;
            store_we    = 1'b1;
            store_waddr = tail_next;
         end else if (is_pop && empty_ff) begin
            status_in = ST_UNDERFLOW;
         end else if (is_pop && head_ff == tail_ff) begin
            status_in = ST_OK;
            empty_in  = 1'b1;
            head_in   = '0;
            tail_in   = '0;
         end else if (req_operation == OP_POP_FRONT) begin
            status_in = ST_OK;
            head_in   = head_next;
         end else if (req_operation == OP_POP_REAR) begin
            status_in = ST_OK;
            tail_in   = tail_prev;
         end else begin
            // no operation, including unused codes
            status_in = ST_OK;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         empty_ff    <= 1'b1;
         capacity_ff <= CAPACITY_RESET;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         if (cap_we && empty_ff) capacity_ff <= cap_wdata;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // ring store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (store_we) store_mem[store_waddr] <= store_wdata;
      rd_front_ff <= store_mem[head_ff];
      rd_rear_ff  <= store_mem[tail_ff];
   end

   // sign extend narrow stored values to the result width, cut wide ones
   generate
      if (VALUE_WIDTH >= 32) begin : g_rd_wide
         assign front_ext = rd_front_ff[31:0];
         assign rear_ext  = rd_rear_ff[31:0];
      end else begin : g_rd_narrow
         assign front_ext = {{(32-VALUE_WIDTH){rd_front_ff[VALUE_WIDTH-1]}}, rd_front_ff};
         assign rear_ext  = {{(32-VALUE_WIDTH){rd_rear_ff[VALUE_WIDTH-1]}}, rd_rear_ff};
      end
   endgenerate

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff     <= status_ff;
         rsp_front_ff      <= empty_ff ? '0 : front_ext;
         rsp_rear_ff       <= empty_ff ? '0 : rear_ext;
         rsp_valid_flag_ff <= !empty_ff;
         rsp_empty_ff      <= empty_ff;
         rsp_full_ff       <= full_now;
      end
   end

   assign cap_value        = capacity_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_front_value  = rsp_front_ff;
   assign rsp_rear_value   = rsp_rear_ff;
   assign rsp_values_valid = rsp_valid_flag_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_is_full      = rsp_full_ff;

`ifndef ASSERT_OFF
   // an empty queue always parks both pointers at the ring start
   a_empty_park: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty queue with moved pointers");

   // live pointers stay inside the ring part in use
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (CAP_W'(head_ff) < cap_eff && CAP_W'(tail_ff) < cap_eff))
      else $error("pointer beyond capacity");

   // a rejected push leaves the queue untouched
   a_overflow_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && is_push && full_now) |=>
         ($stable(head_ff) && $stable(tail_ff) && !empty_ff))
      else $error("overflow changed the queue");
`endif

endmodule

/* dv/tb_double_ended_ring_queue_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_ring_queue_unit
// Self-checking bench for the double-ended ring queue unit. A mirror of the
// deque predicts every response at request acceptance; a checker compares
// each response field by field. Directed tests cover empty, full, unknown
// opcodes and capacity corner values, then random phases sweep capacities
// with random back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_double_ended_ring_queue_unit;
   import derq_pkg::*;

   localparam int unsigned DEPTH          = 16;
   localparam int unsigned VALUE_WIDTH    = 32;
   localparam int unsigned RESULT_LATENCY = 3;
   localparam int unsigned CYCLE_LIMIT    = 600000;
   localparam int unsigned PHASE_ITEMS    = 115;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR =
      CSR_ADDR_W'(4 * int'(CSR_IDX_CAPACITY));

   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] front_value;
      logic signed [31:0] rear_value;
      logic               values_valid;
      logic               is_empty;
      logic               is_full;
   } deque_result_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_operation  = OP_NONE;
   logic signed [31:0]    req_push_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [1:0]            rsp_status;
   logic signed [31:0]    rsp_front_value;
   logic signed [31:0]    rsp_rear_value;
   logic                  rsp_values_valid;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // mirror of the deque state
   logic signed [31:0]    ring_mirror [DEPTH] = '{default: '0};
   int unsigned           head_pos        = 0;
   int unsigned           tail_pos        = 0;
   bit                    mirror_empty    = 1'b1;
   logic [CAPACITY_W-1:0] mirror_capacity = CAPACITY_RESET;

   deque_result_type      expected_results [$];
   int unsigned           fail_count     = 0;
   int unsigned           cycle_count    = 0;
   bit                    no_idle        = 1'b0;
   int unsigned           rsp_hold_req   = 0;
   int unsigned           rsp_stall_left = 0;
   int unsigned           rsp_run_left   = 0;

   double_ended_ring_queue_unit #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_front_value  (rsp_front_value),
      .rsp_rear_value   (rsp_rear_value),
      .rsp_values_valid (rsp_values_valid),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("double_ended_ring_queue_unit verification failed");
      $finish;
   end

   // ring position helpers, capacity already clamped
   function automatic int unsigned ring_next(input int unsigned p, input int unsigned cap);
      return (p + 1 >= cap) ? 0 : p + 1;
   endfunction

   function automatic int unsigned ring_prev(input int unsigned p, input int unsigned cap);
      return (p == 0 || p >= cap) ? cap - 1 : p - 1;
   endfunction

   // register value 0 acts as 1, above DEPTH acts as DEPTH
   function automatic int unsigned usable_depth();
      int unsigned c;
      c = mirror_capacity;
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic bit ring_full(input int unsigned cap);
      return !mirror_empty && head_pos == ring_next(tail_pos, cap);
   endfunction

   // apply one request to the mirror and return the response it causes
   function automatic deque_result_type apply_request(input logic [2:0] op,
                                                      input logic signed [31:0] value);
      int unsigned      cap;
      int unsigned      p;
      deque_result_type r;
      cap      = usable_depth();
      r.status = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (ring_full(cap)) begin
               r.status = ST_OVERFLOW;
            end else begin
               // first entry always lands at position zero
               if (mirror_empty) begin
                  head_pos     = 0;
                  tail_pos     = 0;
                  mirror_empty = 1'b0;
                  p            = 0;
               end else if (op == OP_PUSH_FRONT) begin
                  head_pos = ring_prev(head_pos, cap);
                  p        = head_pos;
               end else begin
                  tail_pos = ring_next(tail_pos, cap);
                  p        = tail_pos;
               end
               ring_mirror[p] = value;
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (mirror_empty) begin
               r.status = ST_UNDERFLOW;
            end else if (head_pos == tail_pos) begin
               mirror_empty = 1'b1;
               head_pos     = 0;
               tail_pos     = 0;
            end else if (op == OP_POP_FRONT) begin
               head_pos = ring_next(head_pos, cap);
            end else begin
               tail_pos = ring_prev(tail_pos, cap);
            end
         end
         default: begin
            // none and unknown codes leave the deque alone
         end
      endcase
      r.front_value  = mirror_empty ? '0 : ring_mirror[head_pos];
      r.rear_value   = mirror_empty ? '0 : ring_mirror[tail_pos];
      r.values_valid = !mirror_empty;
      r.is_empty     = mirror_empty;
      r.is_full      = ring_full(cap);
      return r;
   endfunction

   // idle lengths: mostly short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_pop();
      return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
   endfunction

   function automatic logic [2:0] pick_op(input int unsigned push_pct);
      if ($urandom_range(0, 99) < 4) return 3'($urandom_range(OP_NONE, 7));
      if ($urandom_range(0, 99) < push_pct)
         return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      return pick_pop();
   endfunction

   // response side ready with random stalls and an optional long hold-off
   always @(posedge clock) begin
      if (rsp_hold_req != 0) begin
         rsp_stall_left = rsp_hold_req;
         rsp_hold_req   = 0;
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_run_left > 0) begin
            rsp_run_left--;
         end else begin
            rsp_run_left   = $urandom_range(0, 8);
            rsp_stall_left = pick_gap();
         end
      end
   end

   // response checker
   always @(posedge clock) begin : check_responses
      deque_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("response with no pending request");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status mismatch: expected %0d, actual %0d",
                      want.status, rsp_status);
               fail_count++;
            end
            if (rsp_front_value !== want.front_value) begin
               $error("rsp_front_value mismatch: expected %0d, actual %0d",
                      want.front_value, rsp_front_value);
               fail_count++;
            end
            if (rsp_rear_value !== want.rear_value) begin
               $error("rsp_rear_value mismatch: expected %0d, actual %0d",
                      want.rear_value, rsp_rear_value);
               fail_count++;
            end
            if (rsp_values_valid !== want.values_valid) begin
               $error("rsp_values_valid mismatch: expected %0b, actual %0b",
                      want.values_valid, rsp_values_valid);
               fail_count++;
            end
            if (rsp_is_empty !== want.is_empty) begin
               $error("rsp_is_empty mismatch: expected %0b, actual %0b",
                      want.is_empty, rsp_is_empty);
               fail_count++;
            end
            if (rsp_is_full !== want.is_full) begin
               $error("rsp_is_full mismatch: expected %0b, actual %0b",
                      want.is_full, rsp_is_full);
               fail_count++;
            end
         end
      end
   end

   // offer one request, predict at acceptance, then maybe idle
   task automatic send_request(input logic [2:0] op, input logic signed [31:0] value);
      int unsigned gap;
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_push_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(apply_request(op, value));
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and let every outstanding response drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 1) @(posedge clock);
   endtask

   // csr write: setup then access cycle
   task automatic write_capacity(input logic [CAPACITY_W-1:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // writes while the deque holds data are dropped
      if (mirror_empty) mirror_capacity = value;
   endtask

   task automatic drain_queue();
      while (!mirror_empty) send_request(pick_pop(), random_value());
   endtask

   // pops on empty, none and unknown opcodes
   task automatic test_empty_and_unknown();
      send_request(OP_POP_FRONT, random_value());
      send_request(OP_POP_REAR, random_value());
      send_request(OP_NONE, random_value());
      for (int op = OP_NONE + 1; op <= 7; op++) send_request(3'(op), random_value());
   endtask

   // extreme values at both ends, drain to empty
   task automatic test_extremes_both_ends();
      send_request(OP_PUSH_FRONT, 32'sh7fffffff);
      send_request(OP_PUSH_REAR, 32'sh80000000);
      send_request(OP_PUSH_FRONT, -32'sd1);
      send_request(OP_PUSH_REAR, '0);
      send_request(OP_POP_FRONT, random_value());
      send_request(OP_POP_REAR, random_value());
      send_request(OP_POP_FRONT, random_value());
      send_request(OP_POP_REAR, random_value());
      send_request(OP_POP_REAR, random_value());
   endtask

   // capacity zero acts as one, write while holding data is dropped
   task automatic test_capacity_corners();
      write_capacity(5'd0);
      send_request(OP_PUSH_REAR, 32'sh12345678);
      send_request(OP_PUSH_FRONT, random_value());
      send_request(OP_PUSH_REAR, random_value());
      write_capacity(5'd16);
      send_request(OP_PUSH_FRONT, random_value());
      send_request(OP_POP_REAR, random_value());
      write_capacity(5'd31);
   endtask

   // receiver holds off while the sender keeps offering requests
   task automatic test_back_pressure();
      write_capacity(5'd16);
      no_idle      = 1'b1;
      rsp_hold_req = 300;
      for (int i = 0; i < 40; i++) send_request(pick_op(70), random_value());
      no_idle = 1'b0;
      wait_idle();
   endtask

   // one capacity setting, push-heavy and pop-heavy bursts
   task automatic test_random_phase(input logic [CAPACITY_W-1:0] cap, input bit quiet);
      int unsigned sent;
      int unsigned burst;
      int unsigned push_pct;
      drain_queue();
      write_capacity(cap);
      no_idle = quiet;
      sent    = 0;
      while (sent < PHASE_ITEMS) begin
         case ($urandom_range(0, 2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
         endcase
         burst = $urandom_range(5, 30);
         for (int i = 0; i < burst; i++) send_request(pick_op(push_pct), random_value());
         sent += burst;
         // occasional sender pause until every response is back
         if ($urandom_range(0, 9) == 0) wait_idle();
      end
      no_idle = 1'b0;
   endtask

   // main sequence
   initial begin
      logic [CAPACITY_W-1:0] phase_caps [10];
      phase_caps = '{5'd16, 5'd2, 5'd1, 5'd3, 5'd0, 5'd31, 5'd17, 5'd8,
                     CAPACITY_W'($urandom_range(1, 16)), CAPACITY_W'($urandom_range(0, 31))};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_unknown();
      test_extremes_both_ends();
      test_capacity_corners();
      test_back_pressure();
      for (int i = 0; i < 10; i++) test_random_phase(phase_caps[i], i == 6);
      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("double_ended_ring_queue_unit verification clean");
      end else begin
         $display("double_ended_ring_queue_unit verification failed");
      end
      $finish;
   end

endmodule
